>>> hdl/tqe_pkg.sv
package tqe_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned NUM_TIMERS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF  = 48;

  // Fixed field widths of the request and result words.
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned REMAIN_W = 33;

  // At most this many expiries are reported for one tick.
  localparam int unsigned BURST_CAP = 16;

  // Request codes. The remaining code is a no-op that still returns a status word.
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

  // Largest reported time to the next deadline, and the "table empty" marker.
  localparam logic signed [REMAIN_W-1:0] REMAIN_MAX  = 33'sh0_FFFF_FFFF;
  localparam logic signed [REMAIN_W-1:0] REMAIN_NONE = -33'sd1;

  typedef logic signed [REMAIN_W-1:0] remain_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_REM
  } state_e;

endpackage

>>> hdl/tqe_remain.sv
module tqe_remain #(
  parameter int unsigned TIME_BITS = tqe_pkg::TIME_BITS_DEF
) (
  input  logic                 any_i,
  input  logic [TIME_BITS-1:0] best_i,
  input  logic [TIME_BITS-1:0] now_i,
  output tqe_pkg::remain_t     remain_o
);
  import tqe_pkg::*;

  logic [TIME_BITS-1:0] diff;
  logic [63:0]          diff_ext;

  assign diff     = best_i - now_i;
  assign diff_ext = 64'(diff);

  // Saturate to the 32-bit range; a deadline already reached reads as zero.
  always_comb begin
    if (!any_i) begin
      remain_o = REMAIN_NONE;
    end else if (best_i <= now_i) begin
      remain_o = '0;
    end else if (|diff_ext[63:32]) begin
      remain_o = REMAIN_MAX;
    end else begin
      remain_o = remain_t'({1'b0, diff_ext[31:0]});
    end
  end

endmodule

>>> hdl/timer_queue_expiry.sv
// Deadline-ordered timer table with a millisecond clock. A request word is taken when start_i is
// high and busy_o is low: add stores a timer with deadline now + period_ms_i in the lowest free
// slot, remove frees timer_slot_i, and tick advances the clock by one and reports every due timer,
// earliest deadline first, lower slot first on ties, at most sixteen per tick. Results leave on
// the output ports for exactly one cycle each, marked by strobe_o, and the receiver cannot hold
// them off; last_o marks the final result word of a request. Each pass over the slot memory reads
// one slot per cycle through the single read port. An add, a remove or a tick with nothing due
// makes one pass; busy_o stays high until its result word is ready, and the word is strobed in
// the first cycle with busy_o low. A tick that reports k expiries makes k + 1 passes, keeps
// busy_o high until its last result word is ready, and sends one result word after each pass
// but the first. Nothing needs clearing after reset.
module timer_queue_expiry #(
  parameter int unsigned NUM_TIMERS = tqe_pkg::NUM_TIMERS_DEF,
  parameter int unsigned TIME_BITS  = tqe_pkg::TIME_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [tqe_pkg::REQ_W-1:0]    req_type_i,
  input  logic [tqe_pkg::PERIOD_W-1:0] period_ms_i,
  input  logic                         repeat_flag_i,
  input  logic [tqe_pkg::ID_W-1:0]     timer_slot_i,
  output logic                         strobe_o,
  output logic [tqe_pkg::ID_W-1:0]     expired_id_o,
  output logic                         expired_o,
  output logic                         table_full_o,
  output tqe_pkg::remain_t             remain_ms_o,
  output logic                         last_o
);
  import tqe_pkg::*;

  localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int unsigned MEM_W = TIME_BITS + PERIOD_W + 1;
  localparam int unsigned EMIT_W = $clog2(BURST_CAP) + 1;
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(NUM_TIMERS - 1);
  localparam logic [EMIT_W-1:0] EMIT_LIMIT = EMIT_W'(BURST_CAP - 1);

  // Slot memory: each entry holds {deadline, period, repeat}. Valid and fired bits live in
  // flip-flops so that reset empties the table at once.
  logic [MEM_W-1:0] mem [NUM_TIMERS];
  logic [MEM_W-1:0] rd_data_q;

  logic [NUM_TIMERS-1:0] valid_q, fired_q;
  logic [TIME_BITS-1:0]  now_q;

  state_e state_q, state_d;
  logic   accept;
  logic   enter_scan;

  // Latched request word.
  logic [REQ_W-1:0]     op_q;
  logic [PERIOD_W-1:0]  per_q;
  logic                 rep_q;
  logic [TIME_BITS-1:0] dl_q;

  // Scan sequencer: read addresses go out one per cycle, data come back in the next cycle.
  logic [CNT_W-1:0] cnt_q;
  logic             rd_v_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             issue;
  logic             scan_last;

  // Scan results.
  logic                 any_q;
  logic [TIME_BITS-1:0] best_q;
  logic                 free_v_q;
  logic [IDX_W-1:0]     free_idx_q;
  logic                 pk_v_q;
  logic [IDX_W-1:0]     pk_idx_q;
  logic [TIME_BITS-1:0] pk_dl_q;
  logic [PERIOD_W-1:0]  pk_per_q;
  logic                 pk_rep_q;

  // Tick bookkeeping: a picked timer waits in pend until the next scan supplies the
  // remaining time seen after its own rearm or release.
  logic              pend_q;
  logic [IDX_W-1:0]  pend_id_q;
  logic [EMIT_W-1:0] emit_cnt_q;
  logic              cont_q;

  // Result word registers.
  logic             strobe_q;
  logic [ID_W-1:0]  rid_q;
  logic             rexp_q, rfull_q, rlast_q;
  remain_t          remain_q;
  remain_t          remain_calc;

  logic is_tick, take, emit;

  // Fields of the entry being looked at during the scan.
  logic [TIME_BITS-1:0] e_dl;
  logic [PERIOD_W-1:0]  e_per;
  logic                 e_rep;
  logic                 e_valid, e_fired;

  // Memory write port.
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [MEM_W-1:0] wr_data;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign busy_o    = (state_q != ST_IDLE);
  assign is_tick   = (op_q == REQ_TICK);
  assign scan_last = rd_v_q && (rd_idx_q == LAST_IDX);

  assign e_dl    = rd_data_q[MEM_W-1 -: TIME_BITS];
  assign e_per   = rd_data_q[PERIOD_W:1];
  assign e_rep   = rd_data_q[0];
  assign e_valid = valid_q[rd_idx_q];
  assign e_fired = fired_q[rd_idx_q];

  // In a tick, another timer is taken only while the burst limit allows one more word.
  assign take = is_tick && pk_v_q && (!pend_q || (emit_cnt_q < EMIT_LIMIT));
  // The first scan of a tick that finds a due timer produces no word of its own.
  assign emit = !is_tick || pend_q || !pk_v_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = emit ? ST_REM : ST_SCAN;
      end
      ST_REM: begin
        state_d = cont_q ? ST_SCAN : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer controls.
  always_comb begin
    enter_scan = (state_d == ST_SCAN) && (state_q != ST_SCAN);
    issue      = (state_q == ST_SCAN) && (cnt_q < CNT_W'(NUM_TIMERS));
    wr_en      = 1'b0;
    wr_addr    = pk_idx_q;
    wr_data    = {(now_q + TIME_BITS'(pk_per_q)), pk_per_q, 1'b1};
    if (state_q == ST_EVAL) begin
      if (op_q == REQ_ADD) begin
        wr_en   = free_v_q;
        wr_addr = free_idx_q;
        wr_data = {dl_q, per_q, rep_q};
      end else begin
        wr_en = take && pk_rep_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Slot memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_q <= mem[cnt_q[IDX_W-1:0]];
  end

  // Clock, valid and fired bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q   <= '0;
      valid_q <= '0;
      fired_q <= '0;
    end else begin
      if (accept) begin
        if (req_type_i == REQ_TICK) begin
          now_q   <= now_q + TIME_BITS'(1);
          fired_q <= '0;
        end
        if ((req_type_i == REQ_REMOVE) && (32'(timer_slot_i) < NUM_TIMERS)) begin
          valid_q[IDX_W'(timer_slot_i)] <= 1'b0;
        end
      end
      if (state_q == ST_EVAL) begin
        if ((op_q == REQ_ADD) && free_v_q) begin
          valid_q[free_idx_q] <= 1'b1;
        end
        if (take) begin
          fired_q[pk_idx_q] <= 1'b1;
          if (!pk_rep_q) valid_q[pk_idx_q] <= 1'b0;
        end
      end
    end
  end

  // Request word latch.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_type_i;
      per_q <= period_ms_i;
      rep_q <= repeat_flag_i;
      dl_q  <= now_q + TIME_BITS'(period_ms_i);
    end
  end

  // Scan control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      rd_v_q     <= 1'b0;
      pend_q     <= 1'b0;
      emit_cnt_q <= '0;
      cont_q     <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      rd_v_q   <= issue;
      strobe_q <= (state_q == ST_REM);
      if (enter_scan) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (accept) begin
        pend_q     <= 1'b0;
        emit_cnt_q <= '0;
        cont_q     <= 1'b0;
      end
      if (state_q == ST_EVAL) begin
        cont_q <= take;
        if (take) pend_q <= 1'b1;
        if (emit && pend_q) emit_cnt_q <= emit_cnt_q + EMIT_W'(1);
      end
    end
  end

  // Scan datapath: minimum deadline over valid slots and any timer just added, lowest free slot,
  // and in a tick the earliest due timer not yet reported. Ascending order plus a strict compare
  // keeps the lower slot on equal deadlines.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[IDX_W-1:0];
    if (enter_scan) begin
      any_q    <= 1'b0;
      free_v_q <= 1'b0;
      pk_v_q   <= 1'b0;
    end else if (state_q == ST_EVAL) begin
      if ((op_q == REQ_ADD) && free_v_q && (!any_q || (dl_q < best_q))) begin
        any_q  <= 1'b1;
        best_q <= dl_q;
      end
    end else if (rd_v_q) begin
      if (e_valid && (!any_q || (e_dl < best_q))) begin
        any_q  <= 1'b1;
        best_q <= e_dl;
      end
      if (!e_valid && !free_v_q) begin
        free_v_q   <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
      if (is_tick && e_valid && !e_fired && (e_dl <= now_q) &&
          (!pk_v_q || (e_dl < pk_dl_q))) begin
        pk_v_q   <= 1'b1;
        pk_idx_q <= rd_idx_q;
        pk_dl_q  <= e_dl;
        pk_per_q <= e_per;
        pk_rep_q <= e_rep;
      end
    end
  end

  // Result word fields, settled in the evaluate step; the remaining time is registered in ST_REM.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EVAL) begin
      if (take) pend_id_q <= pk_idx_q;
      if (emit) begin
        if ((op_q == REQ_ADD) && free_v_q) begin
          rid_q <= ID_W'(free_idx_q);
        end else if (is_tick && pend_q) begin
          rid_q <= ID_W'(pend_id_q);
        end else begin
          rid_q <= '0;
        end
        rexp_q  <= is_tick && pend_q;
        rfull_q <= (op_q == REQ_ADD) && !free_v_q;
        rlast_q <= !take;
      end
    end
    if (state_q == ST_REM) remain_q <= remain_calc;
  end

  tqe_remain #(
    .TIME_BITS(TIME_BITS)
  ) u_remain (
    .any_i   (any_q),
    .best_i  (best_q),
    .now_i   (now_q),
    .remain_o(remain_calc)
  );

  assign strobe_o     = strobe_q;
  assign expired_id_o = rid_q;
  assign expired_o    = rexp_q;
  assign table_full_o = rfull_q;
  assign remain_ms_o  = remain_q;
  assign last_o       = rlast_q;

endmodule

>>> test/tb_timer_queue_expiry.sv
// Testbench for the deadline-ordered timer table.
//
// Request words go to the block through the start_i / busy_o handshake. A clocked driver takes
// them from a backlog that the main initial block fills. At the edge where a word is taken, the
// driver runs it through a cycle-free model of the timer table that lives in this file. That
// model appends the result words the request must produce to a queue. A clocked monitor
// compares every strobed result word, field by field, against the oldest word in that queue.
//
// Stimulus opens with a short directed sequence: empty-table status, the unused request code,
// removing a free slot, a repeating period-zero timer that may fire only once per tick, the
// largest period for a long time-to-deadline, a full table, and one tick that expires
// fifteen timers in deadline order. After that come random words, weighted toward ticks and
// short periods so that timers keep expiring, rearming and filling the table.
module tb_timer_queue_expiry;
  import tqe_pkg::*;

  localparam int unsigned NUM_SLOTS = NUM_TIMERS_DEF;
  localparam int unsigned CLOCK_W   = TIME_BITS_DEF;

  // The fourth request code does nothing but still returns one status word.
  localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;

  localparam int unsigned RANDOM_WORDS = 500;
  localparam int unsigned IDLE_PCT     = 26;

  typedef struct {
    logic [REQ_W-1:0]    kind;
    logic [PERIOD_W-1:0] period;
    logic                rearm;
    logic [ID_W-1:0]     slot;
    bit                  drain_first;  // hold this word back until every result has come
    bit                  steady;       // the driver never idles in front of this word
  } request_word_t;

  typedef struct {
    logic [ID_W-1:0] id;
    logic            fired;
    logic            full;
    remain_t         remain;
    logic            last;
  } report_word_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                start_i       = 1'b0;
  logic [REQ_W-1:0]    req_type_i    = '0;
  logic [PERIOD_W-1:0] period_ms_i   = '0;
  logic                repeat_flag_i = 1'b0;
  logic [ID_W-1:0]     timer_slot_i  = '0;

  logic            busy_o;
  logic            strobe_o;
  logic [ID_W-1:0] expired_id_o;
  logic            expired_o;
  logic            table_full_o;
  remain_t         remain_ms_o;
  logic            last_o;

  timer_queue_expiry dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .req_type_i    (req_type_i),
    .period_ms_i   (period_ms_i),
    .repeat_flag_i (repeat_flag_i),
    .timer_slot_i  (timer_slot_i),
    .strobe_o      (strobe_o),
    .expired_id_o  (expired_id_o),
    .expired_o     (expired_o),
    .table_full_o  (table_full_o),
    .remain_ms_o   (remain_ms_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Words waiting to be driven, and result words the block still owes.
  request_word_t request_backlog[$];
  report_word_t  timer_reports[$];

  // The table as the block should hold it.
  bit                  slot_live   [NUM_SLOTS];
  logic [CLOCK_W-1:0]  slot_due    [NUM_SLOTS];
  logic [PERIOD_W-1:0] slot_period [NUM_SLOTS];
  bit                  slot_rearm  [NUM_SLOTS];
  logic [CLOCK_W-1:0]  clock_ms = '0;

  int unsigned errors        = 0;
  int unsigned words_queued  = 0;
  int unsigned words_taken   = 0;
  int unsigned words_checked = 0;
  int unsigned expiries_seen = 0;
  int unsigned fulls_seen    = 0;

  // Time left until the earliest live deadline. It reads zero once that deadline has been
  // reached, is capped at the largest 32-bit count, and is the empty marker with no live timer.
  function automatic remain_t time_to_next();
    bit                 found;
    logic [CLOCK_W-1:0] soonest;
    logic [CLOCK_W-1:0] gap;
    found   = 1'b0;
    soonest = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_live[i] && (!found || slot_due[i] < soonest)) begin
        soonest = slot_due[i];
        found   = 1'b1;
      end
    end
    if (!found) return REMAIN_NONE;
    if (soonest <= clock_ms) return '0;
    gap = soonest - clock_ms;
    if (gap[CLOCK_W-1:32] != '0) return REMAIN_MAX;
    return remain_t'({1'b0, gap[31:0]});
  endfunction

  // The time-to-deadline field reflects the table after this word's own action.
  function automatic void owe_report(logic [ID_W-1:0] id, bit fired, bit full, bit last);
    timer_reports.push_back('{id, fired, full, time_to_next(), last});
  endfunction

  function automatic void apply_request(request_word_t w);
    bit placed;
    bit fired_now[NUM_SLOTS];
    int pick;
    int burst;
    case (w.kind)
      REQ_ADD: begin
        // The lowest free slot takes the timer; with none free, nothing is stored.
        placed = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!placed && !slot_live[i]) begin
            slot_live[i]   = 1'b1;
            slot_due[i]    = clock_ms + CLOCK_W'(w.period);
            slot_period[i] = w.period;
            slot_rearm[i]  = w.rearm;
            placed         = 1'b1;
            owe_report(ID_W'(i), 1'b0, 1'b0, 1'b1);
          end
        end
        if (!placed) owe_report('0, 1'b0, 1'b1, 1'b1);
      end
      REQ_REMOVE: begin
        // Removing a slot that is already free changes nothing but still answers.
        slot_live[w.slot] = 1'b0;
        owe_report('0, 1'b0, 1'b0, 1'b1);
      end
      REQ_TICK: begin
        clock_ms = clock_ms + CLOCK_W'(1);
        for (int i = 0; i < NUM_SLOTS; i++) fired_now[i] = 1'b0;
        burst = 0;
        pick  = 0;
        // Due timers go out earliest deadline first, lower slot on a tie. A timer fires at
        // most once per tick, so a rearmed period-zero timer waits for the next tick.
        while (burst < BURST_CAP && pick >= 0) begin
          pick = -1;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_live[i] && !fired_now[i] && slot_due[i] <= clock_ms &&
                (pick < 0 || slot_due[i] < slot_due[pick])) begin
              pick = i;
            end
          end
          if (pick >= 0) begin
            fired_now[pick] = 1'b1;
            if (slot_rearm[pick]) slot_due[pick] = clock_ms + CLOCK_W'(slot_period[pick]);
            else slot_live[pick] = 1'b0;
            owe_report(ID_W'(pick), 1'b1, 1'b0, 1'b0);
            burst++;
          end
        end
        if (burst == 0) owe_report('0, 1'b0, 1'b0, 1'b1);
        else timer_reports[timer_reports.size()-1].last = 1'b1;
      end
      default: begin
        owe_report('0, 1'b0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  function automatic void queue_request(logic [REQ_W-1:0] kind, logic [PERIOD_W-1:0] period,
                                        logic rearm, logic [ID_W-1:0] slot, bit drain_first,
                                        bit steady);
    request_backlog.push_back('{kind, period, rearm, slot, drain_first, steady});
  endfunction

  // Random requests lean on ticks and short periods, so that timers actually come due. Some
  // periods are zero, full range or the largest value, which keeps every period bit moving
  // and gives long times to deadline.
  function automatic void queue_random_request(bit drain_first, bit steady);
    int                  roll;
    int                  shape;
    logic [REQ_W-1:0]    kind;
    logic [PERIOD_W-1:0] period;
    roll   = $urandom_range(99);
    shape  = $urandom_range(99);
    period = $urandom;
    if (roll < 30) begin
      kind = REQ_ADD;
      if (shape < 55) period = $urandom_range(6);
      else if (shape < 70) period = '0;
      else if (shape >= 85) period = '1;
    end else if (roll < 48) begin
      kind = REQ_REMOVE;
    end else if (roll < 95) begin
      kind = REQ_TICK;
    end else begin
      kind = REQ_NOP;
    end
    queue_request(kind, period, 1'($urandom_range(1)), ID_W'($urandom_range(NUM_SLOTS-1)),
                  drain_first, steady);
  endfunction

  // Driver. At each rising edge it first checks whether the word on the ports was taken,
  // and if so runs it through the table model. If the ports are free, it then presents the
  // next word, or idles at random. A word marked to drain first waits until the block owes
  // nothing. start_i gets a single assignment per edge, so back-to-back words keep it high.
  always @(posedge clk_i) begin : drive_proc
    request_word_t w;
    bit            free_to_drive;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      free_to_drive = !(start_i && busy_o);
      if (start_i && !busy_o) begin
        apply_request('{req_type_i, period_ms_i, repeat_flag_i, timer_slot_i, 1'b0, 1'b0});
        words_taken++;
      end
      if (free_to_drive) begin
        if (request_backlog.size() != 0 &&
            !(request_backlog[0].drain_first && timer_reports.size() != 0) &&
            (request_backlog[0].steady || $urandom_range(99) >= IDLE_PCT)) begin
          w = request_backlog.pop_front();
          req_type_i    <= w.kind;
          period_ms_i   <= w.period;
          repeat_flag_i <= w.rearm;
          timer_slot_i  <= w.slot;
          start_i       <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor. The block cannot be stalled, so every strobed word is taken at the edge that
  // ends its cycle and checked against the oldest word the block still owes.
  always @(posedge clk_i) begin : check_proc
    report_word_t want;
    if (rst_ni && strobe_o) begin
      if (timer_reports.size() == 0) begin
        $error("result word with none owed: id %0d expired %0b full %0b remain %0d last %0b",
               expired_id_o, expired_o, table_full_o, remain_ms_o, last_o);
        errors++;
      end else begin
        want = timer_reports.pop_front();
        words_checked++;
        if (want.fired) expiries_seen++;
        if (want.full) fulls_seen++;
        if (expired_id_o !== want.id) begin
          $error("expired_id: expected %0d, got %0d", want.id, expired_id_o);
          errors++;
        end
        if (expired_o !== want.fired) begin
          $error("expired: expected %0b, got %0b", want.fired, expired_o);
          errors++;
        end
        if (table_full_o !== want.full) begin
          $error("table_full: expected %0b, got %0b", want.full, table_full_o);
          errors++;
        end
        if (remain_ms_o !== want.remain) begin
          $error("remain_ms: expected %0d, got %0d", want.remain, remain_ms_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          errors++;
        end
      end
    end
  end

  // A run that stalls well past the slowest legal pace is a failure.
  initial begin
    #10_000_000;
    $display("FAIL timer_queue_expiry");
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_live[i]   = 1'b0;
      slot_due[i]    = '0;
      slot_period[i] = '0;
      slot_rearm[i]  = 1'b0;
    end

    // On an empty table: a tick with nothing due, the unused code, and removing a free slot.
    queue_request(REQ_TICK, '0, 1'b0, '0, 1'b0, 1'b0);
    queue_request(REQ_NOP, '1, 1'b1, '1, 1'b0, 1'b0);
    queue_request(REQ_REMOVE, '0, 1'b0, 4'd15, 1'b0, 1'b0);
    // A repeating period-zero timer is due at once, and the largest period gives a long
    // time-to-deadline once the first timer is removed.
    queue_request(REQ_ADD, '0, 1'b1, '0, 1'b0, 1'b0);
    queue_request(REQ_ADD, '1, 1'b0, '0, 1'b0, 1'b0);
    // Each of these two ticks fires the period-zero timer exactly once.
    queue_request(REQ_TICK, '0, 1'b0, '0, 1'b0, 1'b0);
    queue_request(REQ_TICK, '0, 1'b0, '0, 1'b0, 1'b0);
    queue_request(REQ_REMOVE, '0, 1'b0, 4'd0, 1'b0, 1'b0);
    // Fill the table with a mix of deadlines now and now + 1. Then one more add finds it full.
    // The next tick expires fifteen timers: the period-zero ones go first, and ties go to the
    // lower slot.
    for (int i = 0; i < NUM_SLOTS - 1; i++) begin
      queue_request(REQ_ADD, i[0] ? 32'd0 : 32'd1, i[1], ID_W'(i), 1'b0, 1'b0);
    end
    queue_request(REQ_ADD, 32'd5, 1'b0, '0, 1'b0, 1'b0);
    queue_request(REQ_TICK, '0, 1'b0, '0, 1'b0, 1'b0);
    queue_request(REQ_TICK, '0, 1'b0, '0, 1'b0, 1'b0);

    // Random words. The sender drains the block now and then, and one long stretch runs with
    // no idle cycles at all.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      queue_random_request(n == 0 || n == 100 || n == 300 || n == 420, n >= 150 && n < 250);
    end
    words_queued = request_backlog.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_taken < words_queued || timer_reports.size() != 0) @(posedge clk_i);
    repeat (2 * (NUM_SLOTS + 3)) @(posedge clk_i);

    $display("Sent %0d request words; checked %0d result words, %0d of them expiries",
             words_taken, words_checked, expiries_seen);
    $display("and %0d of them full-table answers, at simulated clock %0d ms.",
             fulls_seen, clock_ms);
    if (errors == 0 && timer_reports.size() == 0) begin
      $display("PASS timer_queue_expiry");
    end else begin
      $display("FAIL timer_queue_expiry");
    end
    $finish;
  end

endmodule
